// File: rtl/bcq_pkg.sv
package bcq_pkg;

	localparam int COORD_W          = 24;
	localparam int PIECE_IDX_W      = 4;
	localparam int SPLIT_LEVELS_DEF = 4;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	typedef struct packed {
		point_t p3;
		point_t p2;
		point_t p1;
		point_t p0;
	} curve_t;

	typedef struct packed {
		coord_t                   start_x;
		coord_t                   start_y;
		coord_t                   ctrl_x;
		coord_t                   ctrl_y;
		coord_t                   end_x;
		coord_t                   end_y;
		logic [PIECE_IDX_W-1:0]   piece_index;
		logic                     last_piece;
	} result_t;

	// (a + b) / 2 rounded toward minus infinity
	function automatic coord_t mid_coord(input coord_t a, input coord_t b);
		logic [COORD_W:0] s;
		s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		return s[COORD_W:1];
	endfunction

	function automatic point_t mid_point(input point_t a, input point_t b);
		point_t m;
		m.x = mid_coord(a.x, b.x);
		m.y = mid_coord(a.y, b.y);
		return m;
	endfunction

endpackage

// File: rtl/bcq_split_cell.sv
module bcq_split_cell #(
	parameter int IDX_W   = 4,
	parameter int SEL_BIT = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  bcq_pkg::curve_t      in_curve,
	input  logic [IDX_W-1:0]     in_idx,
	output logic                 out_valid,
	output bcq_pkg::curve_t      out_curve,
	output logic [IDX_W-1:0]     out_idx
);
	import bcq_pkg::*;

	point_t m0, m1, m2, q0, q1, s;
	curve_t half;

	always_comb begin
		m0 = mid_point(in_curve.p0, in_curve.p1);
		m1 = mid_point(in_curve.p1, in_curve.p2);
		m2 = mid_point(in_curve.p2, in_curve.p3);
		q0 = mid_point(m0, m1);
		q1 = mid_point(m1, m2);
		s  = mid_point(q0, q1);
		// index bit picks the left or right half at this depth
		if (in_idx[SEL_BIT]) begin
			half.p0 = s;
			half.p1 = q1;
			half.p2 = m2;
			half.p3 = in_curve.p3;
		end else begin
			half.p0 = in_curve.p0;
			half.p1 = m0;
			half.p2 = q0;
			half.p3 = s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_curve <= half;
			out_idx   <= in_idx;
		end
	end

endmodule

// File: rtl/bcq_emit.sv
module bcq_emit #(
	parameter int                IDX_W    = 4,
	parameter logic [IDX_W-1:0]  IDX_LAST = '1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  bcq_pkg::curve_t      in_curve,
	input  logic [IDX_W-1:0]     in_idx,
	output logic                 out_valid,
	output bcq_pkg::result_t     out_res
);
	import bcq_pkg::*;

	// (3*(b+c) - (a+d)) / 4, floored, then clamped to the coordinate range
	function automatic coord_t ctrl_coord(input coord_t a, input coord_t b,
	                                      input coord_t c, input coord_t d);
		logic [COORD_W:0]   bc;
		logic [COORD_W:0]   ad;
		logic [COORD_W+2:0] tri3;
		logic [COORD_W+3:0] diff;
		logic [COORD_W+1:0] q;
		coord_t             r;
		bc   = {b[COORD_W-1], b} + {c[COORD_W-1], c};
		ad   = {a[COORD_W-1], a} + {d[COORD_W-1], d};
		tri3 = {bc[COORD_W], bc[COORD_W], bc} + {bc[COORD_W], bc, 1'b0};
		diff = {tri3[COORD_W+2], tri3} - {{3{ad[COORD_W]}}, ad};
		q    = diff[COORD_W+3:2];
		if (q[COORD_W+1:COORD_W-1] == 3'b000 || q[COORD_W+1:COORD_W-1] == 3'b111) begin
			r = q[COORD_W-1:0];
		end else if (q[COORD_W+1]) begin
			r = COORD_MIN;
		end else begin
			r = COORD_MAX;
		end
		return r;
	endfunction

	result_t res;

	always_comb begin
		res.start_x     = in_curve.p0.x;
		res.start_y     = in_curve.p0.y;
		res.ctrl_x      = ctrl_coord(in_curve.p0.x, in_curve.p1.x, in_curve.p2.x,
		                             in_curve.p3.x);
		res.ctrl_y      = ctrl_coord(in_curve.p0.y, in_curve.p1.y, in_curve.p2.y,
		                             in_curve.p3.y);
		res.end_x       = in_curve.p3.x;
		res.end_y       = in_curve.p3.y;
		res.piece_index = PIECE_IDX_W'(in_idx);
		res.last_piece  = (in_idx == IDX_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res <= res;
		end
	end

endmodule

// File: rtl/cubic_bezier_to_quadratics.sv
// cubic bezier to quadratic pieces
//
// s side: one word is one cubic curve, four control points p0..p3 in signed
// fixed point. the curve is cut in half at t = 1/2 SPLIT_LEVELS times and every
// piece leaves on the m side as one quadratic: start point, control point
// (3*(p1+p2) - (p0+p3)) / 4 clamped to 24 bits, end point and piece index.
// m_tlast marks the last piece of a curve.
//
// throughput: one piece word per cycle while m_tready does not stall the chain. the
// input holding register replays the curve once per piece, and s_tready rises in
// the cycle its last piece moves on, so curves follow back to back with no gap on
// m. the first piece reaches m_tvalid through the holding register, one register
// per split cell and the output register.
//
// m_tready low while m_tvalid is high freezes the whole chain, pieces are held and none is dropped.
// reset clears the valid flags and the piece counter; nothing else needs it.
module cubic_bezier_to_quadratics #(
	parameter int SPLIT_LEVELS = bcq_pkg::SPLIT_LEVELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (24 bits each)
	input  logic [191:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// start_x, start_y, ctrl_x, ctrl_y, end_x, end_y (24 bits each),
	// piece_index (4 bits), 4 bits zero pad
	output logic [151:0]  m_tdata,
	output logic          m_tlast
);
	import bcq_pkg::*;

	localparam int               CNT_W    = (SPLIT_LEVELS > 0) ? SPLIT_LEVELS : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << SPLIT_LEVELS) - 1);

	// curve held for the duration of its pieces
	curve_t           curve_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic             adv;
	logic             s_acc;
	curve_t           in_curve;
	result_t          res;

	// chain of split cells, stage 0 is the holding register
	logic             st_valid [SPLIT_LEVELS+1];
	curve_t           st_curve [SPLIT_LEVELS+1];
	logic [CNT_W-1:0] st_idx   [SPLIT_LEVELS+1];

	// the whole chain moves whenever the output register can take a word
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = !busy_q || (adv && cnt_q == CNT_LAST);
	assign s_acc    = s_tvalid && s_tready;

	always_comb begin
		in_curve.p0.x = s_tdata[23:0];
		in_curve.p0.y = s_tdata[47:24];
		in_curve.p1.x = s_tdata[71:48];
		in_curve.p1.y = s_tdata[95:72];
		in_curve.p2.x = s_tdata[119:96];
		in_curve.p2.y = s_tdata[143:120];
		in_curve.p3.x = s_tdata[167:144];
		in_curve.p3.y = s_tdata[191:168];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (s_acc) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (adv && busy_q) begin
			// last piece gone, nothing new waiting
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			curve_q <= in_curve;
		end
	end

	assign st_valid[0] = busy_q;
	assign st_curve[0] = curve_q;
	assign st_idx[0]   = cnt_q;

	// cell k halves the curve and keeps the half named by index bit
	// SPLIT_LEVELS-1-k, so the msb picks the half at the first split
	for (genvar k = 0; k < SPLIT_LEVELS; k++) begin : g_cell
		bcq_split_cell #(
			.IDX_W   (CNT_W),
			.SEL_BIT (SPLIT_LEVELS - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (st_valid[k]),
			.in_curve  (st_curve[k]),
			.in_idx    (st_idx[k]),
			.out_valid (st_valid[k+1]),
			.out_curve (st_curve[k+1]),
			.out_idx   (st_idx[k+1])
		);
	end

	// control point, clamp and output register
	bcq_emit #(
		.IDX_W    (CNT_W),
		.IDX_LAST (CNT_LAST)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (st_valid[SPLIT_LEVELS]),
		.in_curve  (st_curve[SPLIT_LEVELS]),
		.in_idx    (st_idx[SPLIT_LEVELS]),
		.out_valid (m_tvalid),
		.out_res   (res)
	);

	assign m_tdata = {4'b0000, res.piece_index, res.end_y, res.end_x,
	                  res.ctrl_y, res.ctrl_x, res.start_y, res.start_x};
	assign m_tlast = res.last_piece;

endmodule

// File: dv/bcq_piece_checker.sv
`timescale 1ns / 100ps

module bcq_piece_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tready,
	// p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (24 bits each)
	input  logic [191:0]  s_tdata,
	input  logic          m_tvalid,
	input  logic          m_tready,
	// start_x, start_y, ctrl_x, ctrl_y, end_x, end_y (24 bits each),
	// piece_index (4 bits), 4 bits zero pad
	input  logic [151:0]  m_tdata,
	input  logic          m_tlast,
	output int            mismatches,
	output int            pieces_due
);
	import bcq_pkg::*;

	localparam int PIECES     = 1 << SPLIT_LEVELS_DEF;
	localparam int NUM_FIELDS = 8;

	localparam int          FIELD_LSB  [NUM_FIELDS] = '{0, 24, 48, 72, 96, 120, 144, 148};
	localparam logic [23:0] FIELD_MASK [NUM_FIELDS] = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
		24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h00000F, 24'h00000F};
	localparam string       FIELD_NAME [NUM_FIELDS] = '{"start_x", "start_y", "ctrl_x",
		"ctrl_y", "end_x", "end_y", "piece_index", "pad"};

	typedef struct {
		logic [151:0] data;
		logic         last;
	} piece_word_t;

	piece_word_t expected_pieces[$];
	int          pieces_seen;

	initial begin
		mismatches  = 0;
		pieces_seen = 0;
	end

	// midpoint, rounded toward minus infinity
	function automatic longint halve_sum(input longint a, input longint b);
		return (a + b) >>> 1;
	endfunction

	function automatic coord_t clamp_ctrl(input longint v);
		if (v > longint'(COORD_MAX))
			return COORD_MAX;
		if (v < longint'(COORD_MIN))
			return COORD_MIN;
		return coord_t'(v);
	endfunction

	function automatic logic [23:0] field_of(input logic [151:0] data, input int f);
		return 24'(data >> FIELD_LSB[f]) & FIELD_MASK[f];
	endfunction

	task automatic flag_mismatch(input string what, input logic [151:0] got,
			input logic [151:0] want);
		$display("mismatch at piece word %0d: %s got %h want %h",
			pieces_seen, what, got, want);
		mismatches++;
	endtask

	// de casteljau split of one curve word, pieces queued left to right
	task automatic predict_pieces(input logic [191:0] word);
		longint      pt [PIECES][8];   // per piece: ax ay bx by cx cy dx dy
		longint      a, b, c, d, m0, m1, m2, q0, q1, s;
		coord_t      v;
		piece_word_t w;
		int          n;
		for (int i = 0; i < 8; i++) begin
			v = word[24*i +: 24];
			pt[0][i] = longint'(v);
		end
		for (int lvl = 0; lvl < SPLIT_LEVELS_DEF; lvl++) begin
			n = 1 << lvl;
			// descending so the halves never land on a piece still to be split
			for (int k = n - 1; k >= 0; k--) begin
				for (int dim = 0; dim < 2; dim++) begin
					a  = pt[k][dim];
					b  = pt[k][2+dim];
					c  = pt[k][4+dim];
					d  = pt[k][6+dim];
					m0 = halve_sum(a, b);
					m1 = halve_sum(b, c);
					m2 = halve_sum(c, d);
					q0 = halve_sum(m0, m1);
					q1 = halve_sum(m1, m2);
					s  = halve_sum(q0, q1);
					pt[2*k][dim]     = a;
					pt[2*k][2+dim]   = m0;
					pt[2*k][4+dim]   = q0;
					pt[2*k][6+dim]   = s;
					pt[2*k+1][dim]   = s;
					pt[2*k+1][2+dim] = q1;
					pt[2*k+1][4+dim] = m2;
					pt[2*k+1][6+dim] = d;
				end
			end
		end
		for (int k = 0; k < PIECES; k++) begin
			w.data          = '0;
			w.data[23:0]    = pt[k][0][23:0];
			w.data[47:24]   = pt[k][1][23:0];
			w.data[71:48]   = clamp_ctrl((3 * (pt[k][2] + pt[k][4]) - (pt[k][0] + pt[k][6])) >>> 2);
			w.data[95:72]   = clamp_ctrl((3 * (pt[k][3] + pt[k][5]) - (pt[k][1] + pt[k][7])) >>> 2);
			w.data[119:96]  = pt[k][6][23:0];
			w.data[143:120] = pt[k][7][23:0];
			w.data[147:144] = 4'(k);
			w.last          = (k == PIECES - 1);
			expected_pieces.push_back(w);
		end
	endtask

	task automatic check_piece(input logic [151:0] data, input logic last);
		piece_word_t want;
		logic [23:0] got_f, want_f;
		if (expected_pieces.size() == 0) begin
			flag_mismatch("piece word with nothing expected", data, '0);
		end else begin
			want = expected_pieces.pop_front();
			for (int f = 0; f < NUM_FIELDS; f++) begin
				got_f  = field_of(data, f);
				want_f = field_of(want.data, f);
				if (got_f !== want_f)
					flag_mismatch(FIELD_NAME[f], 152'(got_f), 152'(want_f));
			end
			if (last !== want.last)
				flag_mismatch("last_piece", 152'(last), 152'(want.last));
		end
		pieces_seen++;
	endtask

	// output side first, so a stray word is never covered by a fresh curve
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_piece(m_tdata, m_tlast);
			if (s_tvalid && s_tready)
				predict_pieces(s_tdata);
		end
		pieces_due <= expected_pieces.size();
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import bcq_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int LONG_HOLD     = 300;   // receiver hold-off, long enough to back up the input
	localparam int RANDOM_CURVES = 149;
	localparam int CALM_TAIL     = 30;    // last curves go with no idling on either side
	localparam int HOLD_AT       = 50;
	localparam int DRAIN_AT      = 100;

	localparam coord_t PAT_A = 24'h555555;
	localparam coord_t PAT_B = 24'hAAAAAA;

	typedef enum int {
		SPAN_FULL,
		SPAN_NEAR_ZERO,
		SPAN_NEAR_MAX,
		SPAN_NEAR_MIN
	} span_e;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [191:0]  s_tdata;
	logic          m_tvalid;
	logic          m_tready;
	logic [151:0]  m_tdata;
	logic          m_tlast;

	int mismatches;
	int pieces_due;
	bit calm;          // no idling from here on
	bit hold_req;      // ask the receiver for its long hold-off
	bit hold_done;
	int quiet_words;   // sender stretch with no gaps

	cubic_bezier_to_quadratics u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	bcq_piece_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.pieces_due (pieces_due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// curve word, p0_x in the lowest bits
	function automatic logic [191:0] curve_word(input coord_t p0x, input coord_t p0y,
			input coord_t p1x, input coord_t p1y, input coord_t p2x, input coord_t p2y,
			input coord_t p3x, input coord_t p3y);
		return {p3y, p3x, p2y, p2x, p1y, p1x, p0y, p0x};
	endfunction

	function automatic coord_t rand_coord(input span_e span);
		case (span)
			SPAN_FULL:      return coord_t'($urandom());
			SPAN_NEAR_ZERO: return coord_t'(int'($urandom_range(0, 2047)) - 1024);
			SPAN_NEAR_MAX:  return COORD_MAX - coord_t'($urandom_range(0, 4095));
			default:        return COORD_MIN + coord_t'($urandom_range(0, 4095));
		endcase
	endfunction

	// mostly each coordinate picks its own span, so extremes mix with small values
	function automatic logic [191:0] random_curve();
		coord_t c [8];
		int     pick;
		pick = $urandom_range(0, 19);
		for (int i = 0; i < 8; i++) begin
			if (pick < 12)
				c[i] = rand_coord(span_e'($urandom_range(0, 3)));
			else if (pick < 17)
				c[i] = rand_coord(SPAN_FULL);
			else
				c[i] = rand_coord(SPAN_NEAR_ZERO);
		end
		return curve_word(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endfunction

	// offer one curve word, return at the edge where it is taken
	task automatic send_curve(input logic [191:0] word);
		if (quiet_words > 0) begin
			quiet_words--;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			quiet_words = $urandom_range(8, 24);
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// wait with the input idle until every expected piece is out
	task automatic drain_pieces();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pieces_due != 0) @(posedge clk);
	endtask

	// receiver: random stall bursts, quiet stretches, one long hold-off
	initial begin : sink
		int quiet_left;
		quiet_left = 0;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && quiet_left == 0 && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
				if (quiet_left > 0)
					quiet_left--;
				else if ($urandom_range(0, 63) == 0)
					quiet_left = $urandom_range(20, 80);
			end
			@(posedge clk);
		end
	end

	initial begin : stimulus
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		calm        = 1'b0;
		hold_req    = 1'b0;
		hold_done   = 1'b0;
		quiet_words = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flat curves at zero and at both ends of the range
		send_curve(curve_word('0, '0, '0, '0, '0, '0, '0, '0));
		send_curve(curve_word(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_curve(curve_word(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		// widest arches, control point pushed hardest
		send_curve(curve_word(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
		send_curve(curve_word(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
		// s shape across the full range
		send_curve(curve_word(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
		send_curve(curve_word(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX));
		// odd negative values, floor rounding of every midpoint
		send_curve(curve_word(coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1),
			coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1)));
		send_curve(curve_word(coord_t'(1), coord_t'(-1), coord_t'(-3), coord_t'(3),
			coord_t'(5), coord_t'(-5), coord_t'(-7), coord_t'(7)));
		send_curve(curve_word(coord_t'(1), '0, '0, coord_t'(1), coord_t'(-1), '0, '0,
			coord_t'(-1)));
		// arches that hug the range edge, where the control point may clamp
		send_curve(curve_word(coord_t'(COORD_MAX - 4096), coord_t'(COORD_MAX - 4096),
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			coord_t'(COORD_MAX - 4096), coord_t'(COORD_MAX - 4096)));
		send_curve(curve_word(coord_t'(COORD_MIN + 4096), coord_t'(COORD_MIN + 4096),
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			coord_t'(COORD_MIN + 4096), coord_t'(COORD_MIN + 4096)));
		send_curve(curve_word(coord_t'(COORD_MAX - 1), coord_t'(COORD_MIN + 1),
			COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
			coord_t'(COORD_MAX - 3), coord_t'(COORD_MIN + 3)));
		// cusp, control points crossed
		send_curve(curve_word('0, '0, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX, '0, '0));
		// alternating bit patterns on every field
		send_curve(curve_word(PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_B));
		send_curve(curve_word(PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, PAT_A));
		repeat (5) send_curve(random_curve());

		for (int i = 0; i < RANDOM_CURVES; i++) begin
			if (i == HOLD_AT)
				hold_req = 1'b1;
			if (i == DRAIN_AT)
				drain_pieces();
			if (i == RANDOM_CURVES - CALM_TAIL)
				calm = 1'b1;
			send_curve(random_curve());
		end

		drain_pieces();
		// room for any stray word behind the last piece
		repeat (SPLIT_LEVELS_DEF + 8) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: cubic_bezier_to_quadratics.f
rtl/bcq_pkg.sv
rtl/bcq_split_cell.sv
rtl/bcq_emit.sv
rtl/cubic_bezier_to_quadratics.sv
dv/bcq_piece_checker.sv
dv/tb_top.sv
